// ----- rtl/dual_envelope_transient_shaper_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the transient shaper checker
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_ENVELOPE_TRANSIENT_SHAPER_TOP_MACROS_SVH
`define DUAL_ENVELOPE_TRANSIENT_SHAPER_TOP_MACROS_SVH

// antecedent implies consequent in the next cycle
`define DETS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dets: next-cycle check failed");

// antecedent implies consequent in the same cycle
`define DETS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dets: same-cycle check failed");

`endif

// ----- rtl/dets_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dets_pkg
// Types, register indexes and table builders for the transient shaper.
// ----------------------------------------------------------------------------
package dets_pkg;

	localparam logic [63:0] ONE_Q28  = 64'd1 << 28;
	localparam logic [63:0] LN10_Q28 = 64'd618095479;

	typedef enum logic [2:0] {
		REG_ATTACK_GAIN  = 3'd0,
		REG_SUSTAIN_GAIN = 3'd1,
		REG_SENSITIVITY  = 3'd2,
		REG_MIX          = 3'd3,
		REG_FAST_ATTACK  = 3'd4,
		REG_FAST_RELEASE = 3'd5,
		REG_SLOW_ATTACK  = 3'd6,
		REG_SLOW_RELEASE = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FAST_A,
		ST_FAST_B,
		ST_FAST_WR,
		ST_SLOW_B,
		ST_SLOW_WR,
		ST_DIFF,
		ST_WEIGHT,
		ST_DB_A,
		ST_DB_B,
		ST_GAIN,
		ST_MIX,
		ST_BLEND,
		ST_LEFT,
		ST_RIGHT,
		ST_OUT
	} dets_state_t;

	// shift-subtract divide, elaboration use only
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-y, y in Q.28 (0..16), result Q.28
	function automatic logic [63:0] exp_neg_q28(input logic [63:0] y);
		logic [63:0] r;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] v;
		r = y >> 4;
		sum = ONE_Q28;
		term = ONE_Q28;
		for (int k = 1; k < 40; k++) begin
			if (term != 64'd0) begin
				term = udiv((term * r) >> 28, 64'(k));
				sum = sum + term;
			end
		end
		v = udiv((ONE_Q28 << 28) + (sum >> 1), sum);
		for (int i = 0; i < 4; i++)
			v = (v * v + (ONE_Q28 >> 1)) >> 28;
		return v;
	endfunction

	function automatic logic [16:0] tanh_entry(input int k, input int depth);
		logic [63:0] y;
		logic [63:0] e;
		logic [63:0] den;
		y = udiv(64'(k) << 31, 64'(depth));
		e = exp_neg_q28(y);
		den = ONE_Q28 + e;
		return 17'(udiv(((ONE_Q28 - e) << 16) + (den >> 1), den));
	endfunction

	// 10^(t/200) in Q.16, t in -256..255
	function automatic logic [20:0] gain_entry(input int t);
		logic [63:0] mag;
		logic [63:0] e;
		mag = (t < 0) ? 64'(-t) : 64'(t);
		e = exp_neg_q28(udiv(mag * LN10_Q28 + 64'd100, 64'd200));
		if (t <= 0)
			return 21'((e + 64'd2048) >> 12);
		else
			return 21'(udiv((64'd1 << 44) + (e >> 1), e));
	endfunction

endpackage

// ----- rtl/dets_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dets_in_if
// Input stereo frame channel.
// ----------------------------------------------------------------------------
interface dets_in_if #(parameter int W = 24);
	logic         valid;
	logic         ready;
	logic [W-1:0] left_in;
	logic [W-1:0] right_in;

	modport source (output valid, left_in, right_in, input ready);
	modport sink   (input valid, left_in, right_in, output ready);
endinterface

// ----- rtl/dets_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dets_out_if
// Output stereo frame channel.
// ----------------------------------------------------------------------------
interface dets_out_if #(parameter int W = 24);
	logic         valid;
	logic         ready;
	logic [W-1:0] left_out;
	logic [W-1:0] right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink   (input valid, left_out, right_out, output ready);
endinterface

// ----- rtl/dual_envelope_transient_shaper_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_envelope_transient_shaper_top
// Stereo transient shaper: fast/slow envelope detector, blended dB gain.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one stereo word (left_in, right_in); the left magnitude
//   drives detection. out_ch returns the shaped word (left_out, right_out).
//   Both channels use valid/ready; a word moves when both are high. Eight
//   APB registers at byte address 4*i; write only while idle (unenforced).
// Timing:
//   One shared multiplier with a registered product, stepped by a
//   16-state sequencer: the result becomes valid as the sequencer returns to
//   idle, and in_ch.ready rises at that same edge, so a new word is taken
//   only once the last one has reached the output register.
// Stall:
//   The result sits in an output register. A new word may enter while it
//   waits; its sequence holds in the last step until the old word leaves.
// Reset:
//   arst_n clears both envelopes, loads register defaults and empties the
//   output register. Tables are constants, so no warm-up is needed.
// ----------------------------------------------------------------------------
module dual_envelope_transient_shaper_top
	import dets_pkg::*;
#(
	parameter int SAMPLE_BITS      = 24,
	parameter int TANH_TABLE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	dets_in_if.sink           in_ch,
	dets_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SB  = SAMPLE_BITS;
	localparam int OW  = (SB + 1 > 29) ? SB + 1 : 29;
	localparam int PW  = 2 * OW;
	localparam int IW  = $clog2(TANH_TABLE_DEPTH);
	localparam int K20D = 20 * TANH_TABLE_DEPTH;
	localparam logic [PW-1:0] IDX_MAX   = PW'(TANH_TABLE_DEPTH - 1);
	localparam logic [PW-1:0] IDX_ROUND = PW'(1) << (SB + 8);
	localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

	// constant tables
	logic [16:0] tanh_rom [TANH_TABLE_DEPTH];
	logic [20:0] gain_rom [512];

	for (genvar k = 0; k < TANH_TABLE_DEPTH; k++) begin : g_tanh
		localparam logic [16:0] V = tanh_entry(k, TANH_TABLE_DEPTH);
		assign tanh_rom[k] = V;
	end
	for (genvar g = 0; g < 512; g++) begin : g_gain
		localparam logic [20:0] V = gain_entry(g - 256);
		assign gain_rom[g] = V;
	end

	// configuration registers
	logic [8:0]  attack_gain_q;
	logic [8:0]  sustain_gain_q;
	logic [10:0] sens_q;
	logic [8:0]  mix_q;
	logic [15:0] fast_att_q;
	logic [15:0] fast_rel_q;
	logic [15:0] slow_att_q;
	logic [15:0] slow_rel_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_gain_q  <= '0;
			sustain_gain_q <= '0;
			sens_q         <= 11'd512;
			mix_q          <= 9'd256;
			fast_att_q     <= 16'd62750;
			fast_rel_q     <= 16'd65508;
			slow_att_q     <= 16'd65490;
			slow_rel_q     <= 16'd65531;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_ATTACK_GAIN:  attack_gain_q  <= pwdata[8:0];
				REG_SUSTAIN_GAIN: sustain_gain_q <= pwdata[8:0];
				REG_SENSITIVITY:  sens_q         <= pwdata[10:0];
				REG_MIX:          mix_q          <= pwdata[8:0];
				REG_FAST_ATTACK:  fast_att_q     <= pwdata[15:0];
				REG_FAST_RELEASE: fast_rel_q     <= pwdata[15:0];
				REG_SLOW_ATTACK:  slow_att_q     <= pwdata[15:0];
				REG_SLOW_RELEASE: slow_rel_q     <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_ATTACK_GAIN:  prdata = {{23{attack_gain_q[8]}}, attack_gain_q};
			REG_SUSTAIN_GAIN: prdata = {{23{sustain_gain_q[8]}}, sustain_gain_q};
			REG_SENSITIVITY:  prdata = {21'd0, sens_q};
			REG_MIX:          prdata = {23'd0, mix_q};
			REG_FAST_ATTACK:  prdata = {16'd0, fast_att_q};
			REG_FAST_RELEASE: prdata = {16'd0, fast_rel_q};
			REG_SLOW_ATTACK:  prdata = {16'd0, slow_att_q};
			REG_SLOW_RELEASE: prdata = {16'd0, slow_rel_q};
		endcase
	end

	// datapath state
	dets_state_t state_q, state_d;
	logic [SB-1:0]        left_q, right_q, peak_q;
	logic [SB-1:0]        fast_q, slow_q;
	logic signed [PW-1:0] prod_q, acc_q;
	logic signed [OW-1:0] opa, opb;
	logic                 neg_q;
	logic [17:0]          w2_q;
	logic [20:0]          gain_q;
	logic [21:0]          blend_q;
	logic [SB-1:0]        lres_q;
	logic [SB-1:0]        out_left_q, out_right_q;
	logic                 ovalid_q;

	logic                 in_acc;
	logic                 out_free;
	logic [15:0]          fast_c, slow_c;
	logic [16:0]          fast_ci, slow_ci;
	logic [SB:0]          diff;
	logic [SB-1:0]        diff_mag;
	logic [PW-1:0]        sum_lvl;
	logic [PW-1:0]        idx_sum;
	logic [PW-1:0]        idx_full;
	logic [IW-1:0]        idx;
	logic [16:0]          tval;
	logic signed [PW-1:0] db_sum;
	logic [8:0]           m_clip;
	logic [29:0]          blend_sum;
	logic signed [PW-1:0] shp;
	logic [SB-1:0]        shp_sat;
	logic [SB:0]          left_neg;

	assign in_acc   = in_ch.valid & in_ch.ready;
	assign out_free = ~ovalid_q | out_ch.ready;

	assign fast_c  = (peak_q > fast_q) ? fast_att_q : fast_rel_q;
	assign slow_c  = (peak_q > slow_q) ? slow_att_q : slow_rel_q;
	assign fast_ci = 17'h10000 - {1'b0, fast_c};
	assign slow_ci = 17'h10000 - {1'b0, slow_c};
	assign diff     = {1'b0, fast_q} - {1'b0, slow_q};
	assign diff_mag = diff[SB] ? SB'(-diff) : diff[SB-1:0];
	assign sum_lvl  = PW'(acc_q + prod_q) + PW'(32768);

	assign idx_sum  = PW'(prod_q) + IDX_ROUND;
	assign idx_full = idx_sum >> (SB + 9);
	assign idx      = (idx_full > IDX_MAX) ? IW'(TANH_TABLE_DEPTH - 1) : idx_full[IW-1:0];
	assign tval     = tanh_rom[idx];

	assign db_sum    = acc_q + prod_q + PW'(33619968);
	assign m_clip    = (mix_q > 9'd256) ? 9'd256 : mix_q;
	assign blend_sum = {5'd0, 9'd256 - m_clip, 16'd0} + 30'(prod_q) + 30'd128;

	assign shp = (prod_q + PW'(32768)) >>> 16;
	always_comb begin
		priority if (shp > SAT_HI)
			shp_sat = SAT_HI[SB-1:0];
		else if (shp < SAT_LO)
			shp_sat = SAT_LO[SB-1:0];
		else
			shp_sat = shp[SB-1:0];
	end

	assign left_neg = -{in_ch.left_in[SB-1], in_ch.left_in};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_acc) state_d = ST_FAST_A;
			ST_FAST_A:  state_d = ST_FAST_B;
			ST_FAST_B:  state_d = ST_FAST_WR;
			ST_FAST_WR: state_d = ST_SLOW_B;
			ST_SLOW_B:  state_d = ST_SLOW_WR;
			ST_SLOW_WR: state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_WEIGHT;
			ST_WEIGHT:  state_d = ST_DB_A;
			ST_DB_A:    state_d = ST_DB_B;
			ST_DB_B:    state_d = ST_GAIN;
			ST_GAIN:    state_d = ST_MIX;
			ST_MIX:     state_d = ST_BLEND;
			ST_BLEND:   state_d = ST_LEFT;
			ST_LEFT:    state_d = ST_RIGHT;
			ST_RIGHT:   state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// multiplier operands and handshake
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		opa = '0;
		opb = '0;
		unique case (state_q)
			ST_FAST_A: begin
				opa = {{(OW-17){1'b0}}, fast_ci};
				opb = {{(OW-SB){1'b0}}, peak_q};
			end
			ST_FAST_B: begin
				opa = {{(OW-16){1'b0}}, fast_c};
				opb = {{(OW-SB){1'b0}}, fast_q};
			end
			ST_FAST_WR: begin
				opa = {{(OW-17){1'b0}}, slow_ci};
				opb = {{(OW-SB){1'b0}}, peak_q};
			end
			ST_SLOW_B: begin
				opa = {{(OW-16){1'b0}}, slow_c};
				opb = {{(OW-SB){1'b0}}, slow_q};
			end
			ST_SLOW_WR: begin
				opa = {{(OW-11){1'b0}}, sens_q};
				opb = OW'(K20D);
			end
			ST_DIFF: begin
				opa = {{(OW-SB){1'b0}}, diff_mag};
				opb = {{(OW-28){1'b0}}, prod_q[27:0]};
			end
			ST_DB_A: begin
				opa = {{(OW-18){1'b0}}, w2_q};
				opb = {{(OW-9){attack_gain_q[8]}}, attack_gain_q};
			end
			ST_DB_B: begin
				opa = {{(OW-18){1'b0}}, 18'h20000 - w2_q};
				opb = {{(OW-9){sustain_gain_q[8]}}, sustain_gain_q};
			end
			ST_MIX: begin
				opa = {{(OW-9){1'b0}}, m_clip};
				opb = {{(OW-21){1'b0}}, gain_q};
			end
			ST_LEFT: begin
				opa = {{(OW-SB){left_q[SB-1]}}, left_q};
				opb = {{(OW-22){1'b0}}, blend_q};
			end
			// right product is held while the output register is busy
			ST_RIGHT, ST_OUT: begin
				opa = {{(OW-SB){right_q[SB-1]}}, right_q};
				opb = {{(OW-22){1'b0}}, blend_q};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fast_q   <= '0;
			slow_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FAST_WR)
				fast_q <= sum_lvl[SB+15:16];
			if (state_q == ST_SLOW_WR)
				slow_q <= sum_lvl[SB+15:16];
			if (state_q == ST_OUT && out_free)
				ovalid_q <= 1'b1;
			else if (out_ch.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(opa) * PW'(opb);
		if (in_acc) begin
			left_q  <= in_ch.left_in;
			right_q <= in_ch.right_in;
			peak_q  <= in_ch.left_in[SB-1] ? left_neg[SB-1:0] : in_ch.left_in;
		end
		if (state_q == ST_FAST_B || state_q == ST_SLOW_B || state_q == ST_DB_B)
			acc_q <= prod_q;
		if (state_q == ST_DIFF)
			neg_q <= diff[SB];
		if (state_q == ST_WEIGHT)
			w2_q <= neg_q ? 18'h10000 - {1'b0, tval} : 18'h10000 + {1'b0, tval};
		if (state_q == ST_GAIN)
			gain_q <= gain_rom[db_sum[25:17]];
		if (state_q == ST_BLEND)
			blend_q <= blend_sum[29:8];
		if (state_q == ST_RIGHT)
			lres_q <= shp_sat;
		if (state_q == ST_OUT && out_free) begin
			out_left_q  <= lres_q;
			out_right_q <= shp_sat;
		end
	end

	assign out_ch.valid     = ovalid_q;
	assign out_ch.left_out  = out_left_q;
	assign out_ch.right_out = out_right_q;

endmodule

// ----- rtl/dets_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dets_chk
// Port-level checks for the transient shaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_envelope_transient_shaper_top_macros.svh"

module dets_chk #(
	parameter int W = 24
) (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [W-1:0] out_left
);

	`DETS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left))
	`DETS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
	`DETS_ASSERT_NEXT(a_no_early_word, in_valid && in_ready, !$rose(out_valid))
	`DETS_ASSERT_NOW(a_word_from_seq, $rose(out_valid), !$past(in_ready))

endmodule

bind dual_envelope_transient_shaper_top dets_chk #(.W(SAMPLE_BITS)) u_dets_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_left  (out_ch.left_out)
);
